[rtl/stns_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table nearest search: shared definitions
// Field widths, register indexes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package stns_pkg;

    localparam int VALUE_W           = 32;
    localparam int INDEX_W           = 10;
    localparam int COUNT_W           = 11;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 11;
    localparam int TABLE_DEPTH_DEF   = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_COUNT = 1'b0,
        REG_DESCENDING  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_PREV,
        ST_HERE,
        ST_FETCH,
        ST_EMIT
    } state_t;

endpackage

[rtl/stns_if.sv]
// ----------------------------------------------------------------------------
// Sorted table nearest search: channel interfaces
// Request, result and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface stns_req_if import stns_pkg::*; ();
    logic                      valid;
    logic                      ready;
    func_t                     func;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] target;

    modport source (output valid, func, entry_index, entry_value, target, input ready);
    modport sink   (input valid, func, entry_index, entry_value, target, output ready);
endinterface

interface stns_rsp_if import stns_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [INDEX_W-1:0]        nearest_index;
    logic signed [VALUE_W-1:0] nearest_value;

    modport source (output valid, nearest_index, nearest_value, input ready);
    modport sink   (input valid, nearest_index, nearest_value, output ready);
endinterface

interface stns_cfg_if import stns_pkg::*; ();
    logic                  valid;
    logic                  ready;
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/sorted_table_nearest_search.sv]
// ----------------------------------------------------------------------------
// Sorted table nearest search
// Holds a sorted table of signed Q16.16 values in one synchronous memory and
// returns, for each query, the index and value of the entry nearest a target.
//
// Usage: the req channel carries write items (func = write) that store
// entry_value at entry_index, and query items (func = query) that search for
// target. Each query yields one transfer on the rsp channel; writes yield
// none. The cfg channel sets entry_count and descending; the user is to write
// them only while the block idles, which the block itself does not enforce.
// A write is stored as it is accepted. A query reads the middle entry as it
// is accepted, then makes P probes, one per cycle through the single memory
// read port, at most ceil(log2(n + 1)) for n entries in use; it then reads
// the found entry, and the entry before it when the two are compared.
// The result register lets the next item be accepted while a result waits.
// When rsp stalls, a finished query holds in the sequencer until the result
// register frees. Reset clears the control state and sets entry_count to 1
// and descending to 0; the table content is undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_nearest_search
    import stns_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    stns_req_if.sink    req,
    stns_rsp_if.source  rsp,
    stns_cfg_if.sink    cfg
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = AW + INDEX_W;

    logic [VALUE_W-1:0] mem [TABLE_DEPTH];

    state_t                    state_reg, state_next;
    logic [CW-1:0]             lo_reg, lo_next;
    logic [CW-1:0]             hi_reg, hi_next;
    logic [CW-1:0]             mid_reg, mid_next;
    logic [CW-1:0]             n_reg, n_next;
    logic [CW-1:0]             pos_reg, pos_next;
    logic signed [VALUE_W-1:0] target_reg, target_next;
    logic signed [VALUE_W-1:0] prev_reg, prev_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [COUNT_W-1:0]        count_reg;
    logic                      desc_reg;
    logic                      out_valid_reg;
    logic [INDEX_W-1:0]        out_index_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [WW-1:0]             wr_idx_ext;
    logic                      req_fire;
    logic                      out_free;

    logic [31:0]               cnt_sat;
    logic [CW-1:0]             n_calc;
    logic                      go_right;
    logic [CW-1:0]             lo_upd, hi_upd, mid_upd;
    logic                      keep_search;
    logic                      past_end;
    logic signed [VALUE_W:0]   diff_prev, diff_here;
    logic [VALUE_W:0]          dist_prev, dist_here;
    logic                      prev_closer;

    assign req_fire   = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign wr_idx_ext = WW'(req.entry_index);

    always_comb
    begin
        if (count_reg == '0)
            cnt_sat = 32'd1;
        else if (32'(count_reg) > 32'(TABLE_DEPTH))
            cnt_sat = 32'(TABLE_DEPTH);
        else
            cnt_sat = 32'(count_reg);
    end
    assign n_calc = CW'(cnt_sat);

    assign go_right    = desc_reg ? (rd_data_reg >= target_reg) : (rd_data_reg < target_reg);
    assign lo_upd      = go_right ? (mid_reg + CW'(1)) : lo_reg;
    assign hi_upd      = go_right ? hi_reg : mid_reg;
    assign mid_upd     = lo_upd + ((hi_upd - lo_upd) >> 1);
    assign keep_search = lo_upd < hi_upd;
    assign past_end    = lo_upd >= n_reg;

    assign diff_prev   = (VALUE_W+1)'(prev_reg) - (VALUE_W+1)'(target_reg);
    assign diff_here   = (VALUE_W+1)'(rd_data_reg) - (VALUE_W+1)'(target_reg);
    assign dist_prev   = diff_prev[VALUE_W] ? (VALUE_W+1)'(0) - diff_prev : diff_prev;
    assign dist_here   = diff_here[VALUE_W] ? (VALUE_W+1)'(0) - diff_here : diff_here;
    assign prev_closer = dist_prev < dist_here;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req.func == FUNC_QUERY)
                    state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (!keep_search)
                begin
                    if (past_end || lo_upd == '0)
                        state_next = ST_FETCH;
                    else
                        state_next = ST_PREV;
                end
            end
            ST_PREV:  state_next = ST_HERE;
            ST_HERE:  state_next = ST_EMIT;
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memory and handshake controls.
    always_comb
    begin
        req.ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && req.func == FUNC_QUERY)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(n_calc >> 1);
                end
                if (req.valid && req.func == FUNC_WRITE)
                    wr_en = wr_idx_ext < WW'(TABLE_DEPTH);
            end
            ST_PROBE:
            begin
                rd_en = 1'b1;
                if (keep_search)
                    rd_addr = AW'(mid_upd);
                else if (past_end)
                    rd_addr = AW'(n_reg - CW'(1));
                else if (lo_upd == '0)
                    rd_addr = '0;
                else
                    rd_addr = AW'(lo_upd - CW'(1));
            end
            ST_PREV:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(pos_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Search datapath.
    always_comb
    begin
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        n_next      = n_reg;
        pos_next    = pos_reg;
        target_next = target_reg;
        prev_next   = prev_reg;
        val_next    = val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req.func == FUNC_QUERY)
                begin
                    target_next = req.target;
                    n_next      = n_calc;
                    lo_next     = '0;
                    hi_next     = n_calc;
                    mid_next    = n_calc >> 1;
                end
            end
            ST_PROBE:
            begin
                lo_next  = lo_upd;
                hi_next  = hi_upd;
                mid_next = mid_upd;
                pos_next = past_end ? (n_reg - CW'(1)) : lo_upd;
            end
            ST_PREV:
            begin
                prev_next = rd_data_reg;
            end
            ST_HERE:
            begin
                if (prev_closer)
                begin
                    val_next = prev_reg;
                    pos_next = pos_reg - CW'(1);
                end
                else
                begin
                    val_next = rd_data_reg;
                end
            end
            ST_FETCH:
            begin
                val_next = rd_data_reg;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx_ext[AW-1:0]] <= req.entry_value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        n_reg      <= n_next;
        pos_reg    <= pos_next;
        target_reg <= target_next;
        prev_reg   <= prev_next;
        val_reg    <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
            desc_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_ENTRY_COUNT: count_reg <= COUNT_W'(cfg.data);
                REG_DESCENDING:  desc_reg  <= cfg.data[0];
                default:         desc_reg  <= desc_reg;
            endcase
        end
    end

    // The result register is loaded when a finished query meets a free slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            out_index_reg <= INDEX_W'(pos_reg);
            out_value_reg <= val_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.nearest_index = out_index_reg;
    assign rsp.nearest_value = out_value_reg;

endmodule

[dv/sorted_table_nearest_search_test.sv]
// ----------------------------------------------------------------------------
// Sorted table nearest search: self-checking testbench
// Loads sorted tables through write transfers and checks every query result
// against known values or a local model of the binary search and neighbour
// choice. A short directed table covers the extremes, then random phases
// vary entry_count, ordering, table content, sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module sorted_table_nearest_search_test;
    import stns_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned ITEM_BUDGET   = 480;
    localparam int unsigned DIRECTED_ROWS = 52;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              reg_sel;
        logic [CFG_DATA_W-1:0] reg_data;
        func_t                 func;
        logic [INDEX_W-1:0]    index;
        logic [VALUE_W-1:0]    value;
        logic [VALUE_W-1:0]    target;
        logic                  known;
        logic [INDEX_W-1:0]    exp_index;
        logic [VALUE_W-1:0]    exp_value;
    } row_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } nearest_t;

    logic clk;
    logic rst_n;

    stns_req_if req_if ();
    stns_rsp_if rsp_if ();
    stns_cfg_if cfg_if ();

    sorted_table_nearest_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    logic signed [VALUE_W-1:0] mirror_table [TABLE_DEPTH_DEF];
    logic [COUNT_W-1:0]        count_setting;
    logic                      descending_setting;
    nearest_t                  pending_nearest [$];
    row_t                      directed_rows [DIRECTED_ROWS];
    int unsigned               burst_left;
    int unsigned               fail_count;
    int unsigned               sent_count;
    bit                        hold_off_start;

    function automatic row_t reg_row(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
        row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_sel = sel;
        r.reg_data = data;
        return r;
    endfunction

    function automatic row_t write_row(logic [INDEX_W-1:0] index, logic [VALUE_W-1:0] value);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.func = FUNC_WRITE;
        r.index = index;
        r.value = value;
        return r;
    endfunction

    function automatic row_t query_row(logic [VALUE_W-1:0] goal);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.func = FUNC_QUERY;
        r.target = goal;
        return r;
    endfunction

    function automatic row_t known_query_row(logic [VALUE_W-1:0] goal,
                                             logic [INDEX_W-1:0] index,
                                             logic [VALUE_W-1:0] value);
        row_t r;
        r = query_row(goal);
        r.known = 1'b1;
        r.exp_index = index;
        r.exp_value = value;
        return r;
    endfunction

    function automatic int unsigned active_entries();
        if (count_setting == '0)
            return 1;
        if (int'(count_setting) > TABLE_DEPTH_DEF)
            return TABLE_DEPTH_DEF;
        return int'(count_setting);
    endfunction

    function automatic nearest_t predict_nearest(logic signed [VALUE_W-1:0] goal);
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned pos;
        longint      d_prev;
        longint      d_here;
        logic        go_right;
        nearest_t    r;
        span = active_entries();
        lo = 0;
        hi = span;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (descending_setting)
                go_right = (mirror_table[mid] >= goal);
            else
                go_right = (mirror_table[mid] < goal);
            if (go_right)
                lo = mid + 1;
            else
                hi = mid;
        end
        pos = lo;
        if (pos >= span)
        begin
            pos = span - 1;
        end
        else if (pos > 0)
        begin
            d_prev = longint'(mirror_table[pos - 1]) - longint'(goal);
            d_here = longint'(mirror_table[pos]) - longint'(goal);
            if (d_prev < 0)
                d_prev = -d_prev;
            if (d_here < 0)
                d_here = -d_here;
            if (d_prev < d_here)
                pos = pos - 1;
        end
        r.index = pos[INDEX_W-1:0];
        r.value = mirror_table[pos];
        return r;
    endfunction

    // Called just after a falling edge; returns just after the next falling
    // edge that follows the transfer, with nothing driven at that edge yet.
    task automatic send_item(row_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_if.valid       <= 1'b1;
        req_if.func        <= r.func;
        req_if.entry_index <= r.index;
        req_if.entry_value <= r.value;
        req_if.target      <= r.target;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sent_count++;
        if (r.func == FUNC_WRITE)
            mirror_table[r.index] = r.value;
        else if (r.known)
            pending_nearest.insert(pending_nearest.size(), {r.exp_index, r.exp_value});
        else
            pending_nearest.insert(pending_nearest.size(),
                                   predict_nearest($signed(r.target)));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_nearest.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= sel;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (sel == REG_ENTRY_COUNT)
            count_setting = data;
        else
            descending_setting = data[0];
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] count_value, logic desc,
                             int unsigned mix_items, bit with_hold);
        int unsigned       span;
        int unsigned       k;
        int unsigned       j;
        int unsigned       pick;
        int unsigned       choice;
        int unsigned       base;
        bit                cluster;
        bit [VALUE_W-1:0]  keys [$];
        longint            lo_b;
        longint            hi_b;
        bit [63:0]         wide;
        row_t              r;
        wait_idle();
        write_reg(REG_DESCENDING, {{(CFG_DATA_W-1){1'b0}}, desc});
        write_reg(REG_ENTRY_COUNT, count_value);
        span = active_entries();

        // Sorting offset-binary keys gives the signed order of the values.
        cluster = ($urandom_range(0, 2) == 0);
        base = $urandom_range(0, 32'hFFFF_FFFF - 8 * span);
        for (k = 0; k < span; k++)
            keys.insert(keys.size(),
                        cluster ? base + $urandom_range(0, 8 * span) : $urandom());
        keys.sort();
        if ($urandom_range(0, 3) == 0)
            keys[0] = '0;
        if ($urandom_range(0, 3) == 0)
            keys[span - 1] = '1;
        if (desc)
            keys.reverse();
        for (k = 0; k < span; k++)
            send_item(write_row(INDEX_W'(k), keys[k] ^ 32'h8000_0000));

        for (k = 0; k < mix_items; k++)
        begin
            if (with_hold && k == 1)
                hold_off_start = 1'b1;
            r = '0;
            r.kind = ROW_ITEM;
            choice = $urandom_range(0, 99);
            j = $urandom_range(0, span - 1);
            if (choice < 70)
            begin
                r.func = FUNC_QUERY;
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    r.target = mirror_table[j] + VALUE_W'($urandom_range(0, 16)) - 32'd8;
                else if (pick < 6 && j > 0)
                    r.target = VALUE_W'((longint'(mirror_table[j - 1])
                                         + longint'(mirror_table[j])) >>> 1);
                else if (pick == 6)
                    r.target = 32'h8000_0000;
                else if (pick == 7)
                    r.target = 32'h7FFF_FFFF;
                else
                    r.target = $urandom();
            end
            else if (choice < 88)
            begin
                lo_b = -64'sd2147483648;
                hi_b = 64'sd2147483647;
                if (descending_setting)
                begin
                    if (j + 1 < span)
                        lo_b = mirror_table[j + 1];
                    if (j > 0)
                        hi_b = mirror_table[j - 1];
                end
                else
                begin
                    if (j > 0)
                        lo_b = mirror_table[j - 1];
                    if (j + 1 < span)
                        hi_b = mirror_table[j + 1];
                end
                if (hi_b < lo_b)
                    hi_b = lo_b;
                wide = {$urandom(), $urandom()};
                r.func = FUNC_WRITE;
                r.index = INDEX_W'(j);
                r.value = VALUE_W'(lo_b + longint'(wide % 64'(hi_b - lo_b + 1)));
            end
            else if (choice < 94)
            begin
                r.func = FUNC_WRITE;
                r.index = INDEX_W'(j);
                r.value = $urandom();
            end
            else
            begin
                r.func = FUNC_WRITE;
                if (span < TABLE_DEPTH_DEF)
                    r.index = INDEX_W'($urandom_range(span, TABLE_DEPTH_DEF - 1));
                else
                    r.index = INDEX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1));
                r.value = $urandom();
            end
            send_item(r);
        end
    endtask

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_table_nearest_search: mismatch");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned hold_left;
        int unsigned pattern_left;
        int unsigned pattern_step;
        int unsigned pattern_mode;
        hold_left = 0;
        pattern_left = 0;
        pattern_step = 0;
        pattern_mode = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_start)
            begin
                hold_off_start = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_mode = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 160);
                    pattern_step = 0;
                end
                pattern_left--;
                pattern_step++;
                case (pattern_mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 99) < 65);
                    2:       rsp_if.ready <= ((pattern_step % 4) != 0);
                    default: rsp_if.ready <= ((pattern_step % 7) < 2);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        nearest_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_nearest.size() == 0)
            begin
                $error("unexpected result transfer: nearest_index %0d, nearest_value %h",
                       rsp_if.nearest_index, rsp_if.nearest_value);
                fail_count++;
            end
            else
            begin
                want = pending_nearest.pop_front();
                if (rsp_if.nearest_index !== want.index)
                begin
                    $error("nearest_index: expected %0d, actual %0d",
                           want.index, rsp_if.nearest_index);
                    fail_count++;
                end
                if (rsp_if.nearest_value !== want.value)
                begin
                    $error("nearest_value: expected %h, actual %h",
                           want.value, rsp_if.nearest_value);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned phase_no;
        int unsigned mix_items;
        int unsigned count_value;
        logic        desc;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_WRITE;
        req_if.entry_index = '0;
        req_if.entry_value = '0;
        req_if.target = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_ENTRY_COUNT;
        cfg_if.data = '0;
        count_setting = 11'd1;
        descending_setting = 1'b0;
        burst_left = 0;
        fail_count = 0;
        sent_count = 0;
        hold_off_start = 1'b0;
        foreach (mirror_table[i])
            mirror_table[i] = '0;

        // The last rows saturate the count to the full table in descending
        // order; only the entries on the two extreme search paths are written.
        directed_rows = '{
            write_row(10'd0, 32'h7FFF_FFFF),
            known_query_row(32'h8000_0000, 10'd0, 32'h7FFF_FFFF),
            known_query_row(32'h7FFF_FFFF, 10'd0, 32'h7FFF_FFFF),
            reg_row(REG_ENTRY_COUNT, 11'd4),
            write_row(10'd0, 32'h8000_0000),
            write_row(10'd1, 32'h0000_0000),
            write_row(10'd2, 32'h0001_0000),
            write_row(10'd3, 32'h4000_0000),
            known_query_row(32'h8000_0000, 10'd0, 32'h8000_0000),
            known_query_row(32'h7FFF_FFFF, 10'd3, 32'h4000_0000),
            known_query_row(32'h0000_8000, 10'd2, 32'h0001_0000),
            query_row(32'h0000_7FFF),
            query_row(32'h0001_0000),
            query_row(32'h2000_0000),
            reg_row(REG_ENTRY_COUNT, 11'd2),
            write_row(10'd1, 32'h7FFF_FFFF),
            known_query_row(32'h0000_0000, 10'd1, 32'h7FFF_FFFF),
            query_row(32'hFFFF_FFFF),
            reg_row(REG_DESCENDING, 11'd1),
            reg_row(REG_ENTRY_COUNT, 11'd3),
            write_row(10'd0, 32'h7FFF_FFFF),
            write_row(10'd1, 32'h0000_0000),
            write_row(10'd2, 32'h8000_0000),
            query_row(32'h0000_0000),
            known_query_row(32'h8000_0000, 10'd2, 32'h8000_0000),
            query_row(32'h7FFF_FFFF),
            query_row(32'h0000_0001),
            reg_row(REG_ENTRY_COUNT, 11'd0),
            known_query_row(32'h1234_5678, 10'd0, 32'h7FFF_FFFF),
            reg_row(REG_ENTRY_COUNT, 11'd2047),
            write_row(10'd0, 32'h4000_0000),
            write_row(10'd1, 32'h3000_0000),
            write_row(10'd2, 32'h2000_0000),
            write_row(10'd4, 32'h1000_0000),
            write_row(10'd8, 32'h0800_0000),
            write_row(10'd16, 32'h0400_0000),
            write_row(10'd32, 32'h0200_0000),
            write_row(10'd64, 32'h0100_0000),
            write_row(10'd128, 32'h0080_0000),
            write_row(10'd256, 32'h0040_0000),
            write_row(10'd512, 32'h0000_0000),
            write_row(10'd768, 32'hF000_0000),
            write_row(10'd896, 32'hE000_0000),
            write_row(10'd960, 32'hD000_0000),
            write_row(10'd992, 32'hC800_0000),
            write_row(10'd1008, 32'hC400_0000),
            write_row(10'd1016, 32'hC200_0000),
            write_row(10'd1020, 32'hC100_0000),
            write_row(10'd1022, 32'hC080_0000),
            write_row(10'd1023, 32'hC000_0000),
            known_query_row(32'h8000_0000, 10'd1023, 32'hC000_0000),
            known_query_row(32'h7FFF_FFFF, 10'd0, 32'h4000_0000)
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_data);
            end
            else
            begin
                send_item(directed_rows[i]);
            end
        end

        phase_no = 0;
        while (sent_count < ITEM_BUDGET || phase_no < 4)
        begin
            case (phase_no)
                1:       count_value = 0;
                default: count_value = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 120)
                                                                   : $urandom_range(1, 16);
            endcase
            if (phase_no < 4)
                desc = phase_no[0];
            else
                desc = 1'($urandom_range(0, 1));
            mix_items = $urandom_range(20, 60);
            run_phase(CFG_DATA_W'(count_value), desc, mix_items, phase_no == 3);
            phase_no++;
        end

        wait_idle();
        if (fail_count == 0 && pending_nearest.size() == 0)
            $display("sorted_table_nearest_search: match");
        else
            $display("sorted_table_nearest_search: mismatch");
        $finish;
    end

endmodule
